// ----- rtl/iarr_pkg.sv -----
// shared types and constants for the indexed array list
`default_nettype none

package iarr_pkg;

    // capacity and word size of the list
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // widths of the request and result fields
    localparam int POS_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int FLD_DW = 32;
    localparam int FLD_CW = 5;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CMP_W-1:0]      t_cmp;

    // request kinds
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // what one cell does at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LOWER = 2'd2,
        CELL_FROM_UPPER = 2'd3
    } t_cell_op;

endpackage

`default_nettype wire

// ----- rtl/iarr_if.sv -----
// request and result channel interfaces of the indexed array list
`default_nettype none

interface iarr_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [iarr_pkg::POS_W-1:0] position;
    logic [31:0]                item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink (input valid, input req_type, input position, input item_value,
                  output ready);
endinterface

interface iarr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [iarr_pkg::FLD_DW-1:0] read_value;
    logic [iarr_pkg::FLD_CW-1:0] count;
    logic                        is_empty;
    logic [1:0]                  status;

    modport source (output valid, output read_value, output count, output is_empty,
                    output status, input ready);
    modport sink (input valid, input read_value, input count, input is_empty,
                  input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/indexed_array_list.sv -----
// Fixed-capacity ordered list of data words built as a row of cells. Each request
// (append, insert at index, erase at index, read at index) is checked against the
// entry count and every cell moves, loads or holds its word at the accepting edge, so
// a new request is accepted in every cycle unless the receiver holds the result register.
// The result is in the output register from the cycle after acceptance and the next
// request is taken while it waits, unless that register is still held. Storage
// contents are undefined after reset; only entries below the count are ever read.
`default_nettype none

module indexed_array_list (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iarr_req_if.sink   i_req,
    iarr_rsp_if.source o_rsp
);

    iarr_pkg::t_data  w_cell_q [iarr_pkg::DEPTH];
    iarr_pkg::t_cell_op w_cell_op [iarr_pkg::DEPTH];

    iarr_pkg::t_cnt r_count;
    iarr_pkg::t_cnt n_count;

    logic                r_rsp_valid;
    iarr_pkg::t_data     r_read_value;
    iarr_pkg::t_data     n_read_value;
    iarr_pkg::t_cnt      r_rsp_count;
    logic                r_is_empty;
    iarr_pkg::t_status   r_status;
    iarr_pkg::t_status   n_status;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    iarr_pkg::t_req_type w_type;
    iarr_pkg::t_cmp     w_pos;
    iarr_pkg::t_cmp     w_cnt;
    iarr_pkg::t_cmp     w_ins_pos;
    iarr_pkg::t_data    w_word;
    logic               w_do_ins;
    logic               w_do_era;

    // request handshake: output register frees up when taken
    assign i_req.ready = i_rst_n && (!r_rsp_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_type  = iarr_pkg::t_req_type'(i_req.req_type);
    assign w_pos   = iarr_pkg::t_cmp'(i_req.position);
    assign w_cnt   = iarr_pkg::t_cmp'(r_count);
    assign w_word  = iarr_pkg::t_data'(i_req.item_value);
    assign w_full  = (r_count == iarr_pkg::t_cnt'(iarr_pkg::DEPTH));
    assign w_empty = (r_count == '0);
    assign w_ins_pos = (w_type == iarr_pkg::REQ_APPEND) ? w_cnt : w_pos;

    // request checks, status and count update
    always_comb begin
        n_status     = iarr_pkg::ST_OK;
        n_count      = r_count;
        n_read_value = '0;
        w_do_ins     = 1'b0;
        w_do_era     = 1'b0;
        unique case (w_type)
            iarr_pkg::REQ_APPEND: begin
                if (w_full) begin
                    n_status = iarr_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            iarr_pkg::REQ_INSERT: begin
                priority if (w_full) begin
                    n_status = iarr_pkg::ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_status = iarr_pkg::ST_BAD_INDEX;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            iarr_pkg::REQ_ERASE: begin
                priority if (w_empty) begin
                    n_status = iarr_pkg::ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    n_status = iarr_pkg::ST_BAD_INDEX;
                end else begin
                    w_do_era = 1'b1;
                end
            end
            default: begin
                priority if (w_empty) begin
                    n_status = iarr_pkg::ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    n_status = iarr_pkg::ST_BAD_INDEX;
                end else begin
                    n_read_value = w_cell_q[iarr_pkg::t_idx'(w_pos)];
                end
            end
        endcase
        if (w_do_ins) begin
            n_count = r_count + iarr_pkg::t_cnt'(1);
        end else if (w_do_era) begin
            n_count = r_count - iarr_pkg::t_cnt'(1);
        end
    end

    // row of cells with per-cell move control
    for (genvar k = 0; k < iarr_pkg::DEPTH; k++) begin : g_cell
        iarr_pkg::t_data w_lower;
        iarr_pkg::t_data w_upper;

        always_comb begin
            w_cell_op[k] = iarr_pkg::CELL_HOLD;
            if (w_accept && w_do_ins) begin
                if (iarr_pkg::t_cmp'(k) == w_ins_pos) begin
                    w_cell_op[k] = iarr_pkg::CELL_LOAD;
                end else if (iarr_pkg::t_cmp'(k) > w_ins_pos) begin
                    w_cell_op[k] = iarr_pkg::CELL_FROM_LOWER;
                end
            end else if (w_accept && w_do_era) begin
                if (iarr_pkg::t_cmp'(k) >= w_pos) begin
                    w_cell_op[k] = iarr_pkg::CELL_FROM_UPPER;
                end
            end
        end

        if (k == 0) begin : g_first
            assign w_lower = w_word;
        end else begin : g_mid_lo
            assign w_lower = w_cell_q[k-1];
        end
        if (k == iarr_pkg::DEPTH - 1) begin : g_last
            assign w_upper = w_cell_q[k];
        end else begin : g_mid_hi
            assign w_upper = w_cell_q[k+1];
        end

        iarr_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op[k]),
            .i_word  (w_word),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_q     (w_cell_q[k])
        );
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_rsp_count  <= n_count;
            r_is_empty   <= (n_count == '0);
            r_status     <= n_status;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = iarr_pkg::FLD_DW'(r_read_value);
    assign o_rsp.count      = iarr_pkg::FLD_CW'(r_rsp_count);
    assign o_rsp.is_empty   = r_is_empty;
    assign o_rsp.status     = r_status;

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iarr_pkg::t_cnt'(iarr_pkg::DEPTH))
        else $error("entry count above capacity");

    // accepted append into a list with room grows it by one
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_type == iarr_pkg::REQ_APPEND && !w_full)
        |=> r_count == $past(r_count) + iarr_pkg::t_cnt'(1))
        else $error("append did not grow the list");

    // a full status is only reported for a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_status == iarr_pkg::ST_FULL)
        |-> r_rsp_count == iarr_pkg::t_cnt'(iarr_pkg::DEPTH))
        else $error("full status with room left");

    // empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> (r_is_empty == (r_rsp_count == '0)))
        else $error("empty flag disagrees with count");

    // a rejected request leaves the count unchanged
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status != iarr_pkg::ST_OK) |=> $stable(r_count))
        else $error("rejected request changed the count");

endmodule

`default_nettype wire

// ----- rtl/iarr_cell.sv -----
// one storage cell of the list: holds, loads, or takes a neighbour's word
`default_nettype none

module iarr_cell (
    input  wire logic               i_clk,
    input  wire iarr_pkg::t_cell_op i_op,
    input  wire iarr_pkg::t_data    i_word,
    input  wire iarr_pkg::t_data    i_lower,
    input  wire iarr_pkg::t_data    i_upper,
    output iarr_pkg::t_data         o_q
);

    iarr_pkg::t_data r_q;
    iarr_pkg::t_data n_q;

    // select the next word
    always_comb begin
        unique case (i_op)
            iarr_pkg::CELL_LOAD:       n_q = i_word;
            iarr_pkg::CELL_FROM_LOWER: n_q = i_lower;
            iarr_pkg::CELL_FROM_UPPER: n_q = i_upper;
            default:                   n_q = r_q;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_indexed_array_list.sv -----
// self-checking testbench for the indexed array list: directed table, then random requests
module tb_indexed_array_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1920;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 100;
    localparam int N_DIRECTED  = 20;

    // one result as it leaves the block
    typedef struct packed {
        logic [iarr_pkg::FLD_DW-1:0] read_value;
        logic [iarr_pkg::FLD_CW-1:0] count;
        logic                        is_empty;
        iarr_pkg::t_status           status;
    } t_list_rsp;

    // one line of the directed table, repeated reps times with the word stepped
    typedef struct {
        iarr_pkg::t_req_type kind;
        int                  pos;
        iarr_pkg::t_data     word;
        int                  reps;
        bit                  typed;
        t_list_rsp           rsp;
    } t_stim_row;

    localparam t_list_rsp NO_RSP = '{32'h0, 5'd0, 1'b0, iarr_pkg::ST_OK};

    logic i_clk;
    logic i_rst_n;

    iarr_req_if req_ch ();
    iarr_rsp_if rsp_ch ();

    indexed_array_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow copy of the list
    iarr_pkg::t_data shadow_words [iarr_pkg::DEPTH];
    int              shadow_len;
    t_list_rsp       pending_rsp [$];
    int              n_fail;
    int              item_idx;

    t_stim_row dir_rows [N_DIRECTED] = '{
        '{iarr_pkg::REQ_READ, 0, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd0, 1'b1, iarr_pkg::ST_EMPTY}},
        '{iarr_pkg::REQ_ERASE, 0, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd0, 1'b1, iarr_pkg::ST_EMPTY}},
        '{iarr_pkg::REQ_INSERT, 1, 32'hDEAD_BEEF, 1, 1'b1,
          '{32'h0, 5'd0, 1'b1, iarr_pkg::ST_BAD_INDEX}},
        '{iarr_pkg::REQ_INSERT, 0, 32'hFFFF_FFFF, 1, 1'b1,
          '{32'h0, 5'd1, 1'b0, iarr_pkg::ST_OK}},
        '{iarr_pkg::REQ_APPEND, 31, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd2, 1'b0, iarr_pkg::ST_OK}},
        '{iarr_pkg::REQ_READ, 0, 32'h0000_0000, 1, 1'b1,
          '{32'hFFFF_FFFF, 5'd2, 1'b0, iarr_pkg::ST_OK}},
        '{iarr_pkg::REQ_READ, 2, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd2, 1'b0, iarr_pkg::ST_BAD_INDEX}},
        '{iarr_pkg::REQ_ERASE, 2, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd2, 1'b0, iarr_pkg::ST_BAD_INDEX}},
        '{iarr_pkg::REQ_INSERT, 2, 32'hA5A5_A5A5, 1, 1'b0, NO_RSP},
        '{iarr_pkg::REQ_INSERT, 1, 32'h5A5A_5A5A, 1, 1'b0, NO_RSP},
        '{iarr_pkg::REQ_APPEND, 0, 32'h1357_0000, 12, 1'b0, NO_RSP},
        '{iarr_pkg::REQ_APPEND, 0, 32'h0000_0001, 1, 1'b1,
          '{32'h0, 5'd16, 1'b0, iarr_pkg::ST_FULL}},
        '{iarr_pkg::REQ_INSERT, 0, 32'h0000_0001, 1, 1'b1,
          '{32'h0, 5'd16, 1'b0, iarr_pkg::ST_FULL}},
        '{iarr_pkg::REQ_INSERT, 31, 32'h0000_0001, 1, 1'b1,
          '{32'h0, 5'd16, 1'b0, iarr_pkg::ST_FULL}},
        '{iarr_pkg::REQ_READ, 15, 32'h0000_0000, 1, 1'b0, NO_RSP},
        '{iarr_pkg::REQ_READ, 16, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd16, 1'b0, iarr_pkg::ST_BAD_INDEX}},
        '{iarr_pkg::REQ_READ, 31, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd16, 1'b0, iarr_pkg::ST_BAD_INDEX}},
        '{iarr_pkg::REQ_ERASE, 16, 32'h0000_0000, 1, 1'b1,
          '{32'h0, 5'd16, 1'b0, iarr_pkg::ST_BAD_INDEX}},
        '{iarr_pkg::REQ_ERASE, 0, 32'h0000_0000, 1, 1'b0, NO_RSP},
        '{iarr_pkg::REQ_ERASE, 14, 32'h0000_0000, 1, 1'b0, NO_RSP}
    };

    // apply one request to the shadow list and give the result it causes
    function automatic t_list_rsp list_apply(iarr_pkg::t_req_type kind, int pos,
                                             iarr_pkg::t_data word);
        t_list_rsp r;
        int        k;
        r.read_value = '0;
        r.status     = iarr_pkg::ST_OK;
        case (kind)
            iarr_pkg::REQ_APPEND: begin
                if (shadow_len >= iarr_pkg::DEPTH) begin
                    r.status = iarr_pkg::ST_FULL;
                end else begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
            end
            iarr_pkg::REQ_INSERT: begin
                // full takes precedence over a bad index
                if (shadow_len >= iarr_pkg::DEPTH) begin
                    r.status = iarr_pkg::ST_FULL;
                end else if (pos > shadow_len) begin
                    r.status = iarr_pkg::ST_BAD_INDEX;
                end else begin
                    for (k = shadow_len; k > pos; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[pos] = word;
                    shadow_len++;
                end
            end
            iarr_pkg::REQ_ERASE: begin
                if (shadow_len == 0) begin
                    r.status = iarr_pkg::ST_EMPTY;
                end else if (pos >= shadow_len) begin
                    r.status = iarr_pkg::ST_BAD_INDEX;
                end else begin
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            default: begin
                if (shadow_len == 0) begin
                    r.status = iarr_pkg::ST_EMPTY;
                end else if (pos >= shadow_len) begin
                    r.status = iarr_pkg::ST_BAD_INDEX;
                end else begin
                    r.read_value = iarr_pkg::FLD_DW'(shadow_words[pos]);
                end
            end
        endcase
        r.count    = iarr_pkg::FLD_CW'(shadow_len);
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    // random request: phases that grow, mix and shrink the list, with some noise
    task automatic pick_list_req(input int idx, output iarr_pkg::t_req_type kind,
                                 output int pos, output iarr_pkg::t_data word);
        int r;
        int phase;
        bit bad;
        r     = $urandom_range(0, 99);
        phase = (idx / 32) % 4;
        bad   = ($urandom_range(0, 9) == 0);
        if (r < 8) begin
            kind = iarr_pkg::t_req_type'($urandom_range(0, 3));
        end else begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                kind = (r < 45) ? iarr_pkg::REQ_APPEND : (r < 80) ? iarr_pkg::REQ_INSERT :
                       (r < 90) ? iarr_pkg::REQ_READ : iarr_pkg::REQ_ERASE;
            else if (phase == 2)
                kind = (r < 55) ? iarr_pkg::REQ_ERASE : (r < 65) ? iarr_pkg::REQ_APPEND :
                       (r < 75) ? iarr_pkg::REQ_INSERT : iarr_pkg::REQ_READ;
            else
                kind = iarr_pkg::t_req_type'(r % 4);
        end
        // mostly in-range positions, sometimes past the end
        case (kind)
            iarr_pkg::REQ_APPEND: pos = $urandom_range(0, 31);
            iarr_pkg::REQ_INSERT: begin
                if (bad && shadow_len < 31)
                    pos = $urandom_range(shadow_len + 1, 31);
                else
                    pos = $urandom_range(0, shadow_len);
            end
            default: begin
                if (bad || shadow_len == 0)
                    pos = $urandom_range(shadow_len, 31);
                else
                    pos = $urandom_range(0, shadow_len - 1);
            end
        endcase
        r = $urandom_range(0, 9);
        word = (r == 0) ? '0 : (r == 1) ? '1 : iarr_pkg::t_data'($urandom);
    endtask

    // offer one request, wait for it to be taken, then record what it should give
    task automatic send_req(input iarr_pkg::t_req_type kind, input int pos,
                            input iarr_pkg::t_data word, input bit typed,
                            input t_list_rsp typed_rsp);
        int        gap;
        bit        pause;
        t_list_rsp predicted;
        if ((item_idx >= 400 && item_idx < 520) || (item_idx >= 1200 && item_idx < 1400))
            gap = 0;
        else
            gap = $urandom_range(0, 7);
        pause = (item_idx == 700 || item_idx == 1500);
        if (pause && gap == 0)
            gap = 1;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // drain everything before going on
        if (pause)
            while (pending_rsp.size() != 0) @(posedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.position   <= 5'(pos);
        req_ch.item_value <= word;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        predicted = list_apply(kind, pos, word);
        if (typed)
            predicted = typed_rsp;
        pending_rsp = {pending_rsp, predicted};
        item_idx++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // reset and request side at rest
    initial begin
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= iarr_pkg::REQ_APPEND;
        req_ch.position   <= '0;
        req_ch.item_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // result side: random hold-offs, one long hold, one stretch always ready
    initial begin : rsp_ready_drive
        int gap;
        int n_rsp;
        n_rsp = 0;
        rsp_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (n_rsp == 400)
                gap = LONG_HOLD;
            else if (n_rsp >= 1200 && n_rsp < 1400)
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            n_rsp++;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        t_list_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("result with nothing expected: count %0d status %0d",
                       rsp_ch.count, rsp_ch.status);
                n_fail++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value,
                           rsp_ch.read_value);
                    n_fail++;
                end
                if (rsp_ch.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    n_fail++;
                end
                if (rsp_ch.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %b, got %b", want.is_empty, rsp_ch.is_empty);
                    n_fail++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any request or result moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // main sequence
    initial begin : main_seq
        iarr_pkg::t_req_type kind;
        int                  pos;
        iarr_pkg::t_data     word;
        n_fail     = 0;
        item_idx   = 0;
        shadow_len = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);

        // directed table
        foreach (dir_rows[i]) begin
            for (int j = 0; j < dir_rows[i].reps; j++)
                send_req(dir_rows[i].kind, dir_rows[i].pos,
                         dir_rows[i].word + iarr_pkg::t_data'(j),
                         dir_rows[i].typed, dir_rows[i].rsp);
        end

        // random requests
        for (int n = 0; n < N_RANDOM; n++) begin
            pick_list_req(n, kind, pos, word);
            send_req(kind, pos, word, 1'b0, NO_RSP);
        end
        req_ch.valid <= 1'b0;

        // let the last results come out
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            $error("%0d expected results never arrived", pending_rsp.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- indexed_array_list.f -----
rtl/iarr_pkg.sv
rtl/iarr_if.sv
rtl/iarr_cell.sv
rtl/indexed_array_list.sv
tb/sv/tb_indexed_array_list.sv
